// ===== hw/rtl/emrs_pkg.sv =====
// Shared types, constants and state codes of the extent-mapped read segmenter.
`timescale 1ns / 1ps

package emrs_pkg;

   localparam int MAX_EXTENTS_DEF = 16;
   localparam int BLOCK_BYTES_DEF = 512;
   localparam int MAX_RESULTS     = 64;
   localparam int RES_CNT_W       = 6;

   localparam int POS_W       = 41;
   localparam int LEN_W       = 15;
   localparam int BLK_W       = 32;
   localparam int IDX_FIELD_W = 4;
   localparam int OFF_FIELD_W = 9;
   localparam int CNT_FIELD_W = 10;
   localparam int USE_W       = 5;
   localparam int SUM_W       = 42;   // running extent base, never wraps
   localparam int LIM_W       = 9;    // holds the largest table depth
   localparam int WIDE_W      = 16;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   // Register select is paddr[3]: 8-byte register slots.
   localparam logic CSR_SEL_FILE_SIZE = 1'b0;
   localparam logic CSR_SEL_EXT_USE   = 1'b1;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_SEG      = 2'd0,
      STATUS_NONE     = 2'd1,
      STATUS_UNMAPPED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEG,
      ST_WALK,
      ST_CLIP,
      ST_EMIT,
      ST_UNMAP,
      ST_NONE
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [IDX_FIELD_W-1:0] extent_index;
      logic [BLK_W-1:0]       extent_start;
      logic [BLK_W-1:0]       extent_blocks;
      logic [POS_W-1:0]       read_position;
      logic [LEN_W-1:0]       read_length;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [BLK_W-1:0]       disk_block;
      logic [OFF_FIELD_W-1:0] block_offset;
      logic [CNT_FIELD_W-1:0] byte_count;
      logic [POS_W-1:0]       next_position;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [BLK_W-1:0] start;
      logic [BLK_W-1:0] blocks;
   } extent_type;

endpackage

// ===== hw/rtl/emrs_ext_table.sv =====
// Extent table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module emrs_ext_table
   import emrs_pkg::*;
#(
   parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
   localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1
) (
   input  logic             clock,
   input  logic             wr_en_i,
   input  logic [IDX_W-1:0] wr_addr_i,
   input  extent_type       wr_data_i,
   input  logic [IDX_W-1:0] rd_addr_i,
   output extent_type       rd_data_o
);

   extent_type mem [MAX_EXTENTS];
   extent_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         mem[wr_addr_i] <= wr_data_i;
      end
      rd_data_ff <= mem[rd_addr_i];
   end

   assign rd_data_o = rd_data_ff;

endmodule

// ===== hw/rtl/emrs_pos_div.sv =====
// Position split: block number and in-block offset of a byte position by shift and mask.
`timescale 1ns / 1ps

module emrs_pos_div
   import emrs_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   localparam int OFF_W = $clog2(BLOCK_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_i,
   input  logic [POS_W-1:0] dividend_i,
   output logic             done_o,
   output logic [POS_W-1:0] quot_o,
   output logic [OFF_W-1:0] rem_o
);

   logic             done_ff, done_in;
   logic [POS_W-1:0] quot_ff, quot_in;
   logic [OFF_W-1:0] rem_ff, rem_in;

   // Block size is a power of two: quotient is a shift, remainder the low bits.
   always_comb begin
      done_in = start_i;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start_i) begin
         quot_in = dividend_i >> OFF_W;
         rem_in  = dividend_i[OFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done_o = done_ff;
   assign quot_o = quot_ff;
   assign rem_o  = rem_ff;

endmodule

// ===== hw/rtl/emrs_seq.sv =====
// Read sequencer: per-segment extent walk, clipping and result generation.
`timescale 1ns / 1ps

module emrs_seq
   import emrs_pkg::*;
#(
   parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1,
   localparam int OFF_W = $clog2(BLOCK_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             read_accept_i,
   input  logic [POS_W-1:0] req_pos_i,
   input  logic [LEN_W-1:0] req_len_i,
   input  logic [POS_W-1:0] file_size_i,
   input  logic [USE_W-1:0] ext_use_i,
   output logic             busy_o,
   input  logic             div_done_i,
   input  logic [POS_W-1:0] div_quot_i,
   input  logic [OFF_W-1:0] div_rem_i,
   output logic [IDX_W-1:0] tbl_raddr_o,
   input  extent_type       tbl_rd_i,
   output logic             rsp_valid_o,
   output rsp_type          rsp_o
);

   localparam int BYTES_W = OFF_W + 1;
   localparam int CNT_W   = $clog2(MAX_EXTENTS + 1);

   state_type              state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [SUM_W-1:0]       vbn_ff, vbn_in;
   logic [OFF_W-1:0]       off_ff, off_in;
   logic [POS_W-1:0]       rem_size_ff, rem_size_in;
   logic [SUM_W-1:0]       base_ff, base_in;
   logic [CNT_W-1:0]       walk_idx_ff, walk_idx_in;
   logic [BLK_W-1:0]       hit_start_ff, hit_start_in;
   logic [BLK_W-1:0]       diff_ff, diff_in;
   logic [BLK_W-1:0]       blk_ff, blk_in;
   logic [BYTES_W-1:0]     bytes_ff, bytes_in;
   logic [RES_CNT_W-1:0]   seg_cnt_ff, seg_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [LIM_W-1:0]   use_lim, max_lim, lim;
   logic [CNT_W-1:0]   n_lim;
   logic               none_now;
   logic [SUM_W-1:0]   walk_top;
   logic               walk_hit;
   logic [CNT_W-1:0]   walk_idx_nx;
   logic               walk_last;
   logic [BYTES_W-1:0] avail, clip1, clip2;
   logic [POS_W-1:0]   next_pos;
   logic               last_seg;
   logic [BYTES_W-1:0] off_sum;
   logic               blk_end;

   // Shared datapath terms
   always_comb begin
      use_lim  = LIM_W'(ext_use_i);
      max_lim  = LIM_W'(MAX_EXTENTS);
      lim      = (use_lim > max_lim) ? max_lim : use_lim;
      n_lim    = lim[CNT_W-1:0];
      none_now = (len_ff == '0) || (pos_ff >= file_size_i);

      walk_top    = base_ff + SUM_W'(tbl_rd_i.blocks);
      walk_hit    = (vbn_ff < walk_top);
      walk_idx_nx = walk_idx_ff + CNT_W'(1);
      walk_last   = (walk_idx_nx == n_lim);

      avail = BYTES_W'(BLOCK_BYTES) - BYTES_W'(off_ff);
      clip1 = (rem_size_ff < POS_W'(avail)) ? rem_size_ff[BYTES_W-1:0] : avail;
      clip2 = (WIDE_W'(len_ff) < WIDE_W'(clip1)) ? len_ff[BYTES_W-1:0] : clip1;

      next_pos = pos_ff + POS_W'(bytes_ff);
      last_seg = (WIDE_W'(bytes_ff) == WIDE_W'(len_ff))
              || (POS_W'(bytes_ff) == rem_size_ff)
              || (seg_cnt_ff == RES_CNT_W'(MAX_RESULTS - 1));
      off_sum  = BYTES_W'(off_ff) + bytes_ff;
      blk_end  = (off_sum == BYTES_W'(BLOCK_BYTES));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (read_accept_i) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done_i) begin
               state_in = none_now ? ST_NONE : ST_SEG;
            end
         end
         ST_SEG: begin
            state_in = (n_lim == '0) ? ST_UNMAP : ST_WALK;
         end
         ST_WALK: begin
            if (walk_hit) begin
               state_in = ST_CLIP;
            end else if (walk_last) begin
               state_in = ST_UNMAP;
            end
         end
         ST_CLIP:  state_in = ST_EMIT;
         ST_EMIT:  state_in = last_seg ? ST_IDLE : ST_SEG;
         ST_UNMAP: state_in = ST_IDLE;
         ST_NONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and result registers
   always_comb begin
      pos_in       = pos_ff;
      len_in       = len_ff;
      vbn_in       = vbn_ff;
      off_in       = off_ff;
      rem_size_in  = rem_size_ff;
      base_in      = base_ff;
      walk_idx_in  = walk_idx_ff;
      hit_start_in = hit_start_ff;
      diff_in      = diff_ff;
      blk_in       = blk_ff;
      bytes_in     = bytes_ff;
      seg_cnt_in   = seg_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (read_accept_i) begin
               pos_in     = req_pos_i;
               len_in     = req_len_i;
               seg_cnt_in = '0;
            end
         end
         ST_DIV: begin
            if (div_done_i) begin
               vbn_in = SUM_W'(div_quot_i) + SUM_W'(1);
               off_in = div_rem_i;
            end
         end
         ST_SEG: begin
            rem_size_in = file_size_i - pos_ff;
            base_in     = SUM_W'(1);
            walk_idx_in = '0;
         end
         ST_WALK: begin
            if (walk_hit) begin
               hit_start_in = tbl_rd_i.start;
               diff_in      = BLK_W'(vbn_ff - base_ff);
            end else begin
               base_in     = walk_top;
               walk_idx_in = walk_idx_nx;
            end
         end
         ST_CLIP: begin
            blk_in   = hit_start_ff + diff_ff;
            bytes_in = clip2;
         end
         ST_EMIT: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = STATUS_SEG;
            rsp_in.disk_block    = blk_ff;
            rsp_in.block_offset  = OFF_FIELD_W'(off_ff);
            rsp_in.byte_count    = CNT_FIELD_W'(bytes_ff);
            rsp_in.next_position = next_pos;
            rsp_in.last          = last_seg;
            pos_in     = next_pos;
            len_in     = len_ff - LEN_W'(bytes_ff);
            seg_cnt_in = seg_cnt_ff + RES_CNT_W'(1);
            if (blk_end) begin
               vbn_in = vbn_ff + SUM_W'(1);
               off_in = '0;
            end else begin
               off_in = off_sum[OFF_W-1:0];
            end
         end
         ST_UNMAP: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = STATUS_UNMAPPED;
            rsp_in.disk_block    = '0;
            rsp_in.block_offset  = OFF_FIELD_W'(off_ff);
            rsp_in.byte_count    = '0;
            rsp_in.next_position = pos_ff;
            rsp_in.last          = 1'b1;
         end
         ST_NONE: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = STATUS_NONE;
            rsp_in.disk_block    = '0;
            rsp_in.block_offset  = OFF_FIELD_W'(off_ff);
            rsp_in.byte_count    = '0;
            rsp_in.next_position = pos_ff;
            rsp_in.last          = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_cnt_ff   <= '0;
         walk_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_cnt_ff   <= seg_cnt_in;
         walk_idx_ff  <= walk_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      len_ff       <= len_in;
      vbn_ff       <= vbn_in;
      off_ff       <= off_in;
      rem_size_ff  <= rem_size_in;
      base_ff      <= base_in;
      hit_start_ff <= hit_start_in;
      diff_ff      <= diff_in;
      blk_ff       <= blk_in;
      bytes_ff     <= bytes_in;
      rsp_ff       <= rsp_in;
   end

   // The table is addressed with the next walk index, so its registered read data lines up with the walk compare.
   assign tbl_raddr_o = walk_idx_in[IDX_W-1:0];
   assign busy_o      = (state_ff != ST_IDLE);
   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_o       = rsp_ff;

endmodule

// ===== hw/rtl/extent_mapped_read_segmenter.sv =====
// Top level of the extent-mapped read segmenter: CSRs, extent table, position split, sequencer.
`timescale 1ns / 1ps

// Extent-mapped read segmenter. A load transaction (op = 0) writes one
// extent entry (first disk block, block count) into the table; busy stays
// low. A read transaction (op = 1) splits a byte range into per-block
// segments and maps each 1-based virtual block to a disk block by walking
// the extents in order with a running base. Results come out on
// rsp_valid/rsp_data, one result per strobe, one cycle each; the receiver
// cannot stall them, so it must take every strobe. The final result of a
// read carries last. A read first splits the start position into block
// number and offset (BLOCK_BYTES must be a power of two, so this is a shift
// and a mask), then for each segment sets up the walk, compares one extent
// at a time until the hit, clips the byte count and emits the result; a
// read yields at most 64 results. A read with nothing to read ends with a
// single NONE result; an unmapped block ends the read with an UNMAPPED
// result once the walk passes every extent in use. Each result shows up in
// the cycle after the state that makes it. busy is high for the whole read
// and drops in the cycle of the final result, and start is only taken while
// busy is low. Config registers sit at byte 0 (file_size, 41 bits) and byte
// 8 (extents_in_use, 5 bits) of a 64-bit CSR port, selected by paddr[3];
// write them only while no read is running. Extent entries must be loaded
// before a read reaches them; entries have no reset value.

module extent_mapped_read_segmenter
   import emrs_pkg::*;
#(
   parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   // CSR port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int OFF_W = $clog2(BLOCK_BYTES);

   logic [POS_W-1:0] file_size_ff, file_size_in;
   logic [USE_W-1:0] ext_use_ff, ext_use_in;
   logic             csr_wr;

   logic             accept;
   logic             read_accept;
   logic [LIM_W-1:0] load_idx;
   logic             tbl_wr_en;
   extent_type       tbl_wr_data;
   logic [IDX_W-1:0] tbl_raddr;
   extent_type       tbl_rd;

   logic             div_done;
   logic [POS_W-1:0] div_quot;
   logic [OFF_W-1:0] div_rem;

   // ---------------------------------------------------------------
   // CSR block: zero-wait writes, register picked by paddr[3]
   // ---------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      file_size_in = file_size_ff;
      ext_use_in   = ext_use_ff;
      if (csr_wr) begin
         case (paddr[3])
            CSR_SEL_FILE_SIZE: file_size_in = pwdata[POS_W-1:0];
            CSR_SEL_EXT_USE:   ext_use_in   = pwdata[USE_W-1:0];
            default:           file_size_in = file_size_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3])
         CSR_SEL_FILE_SIZE: prdata = CSR_DATA_W'(file_size_ff);
         CSR_SEL_EXT_USE:   prdata = CSR_DATA_W'(ext_use_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= '0;
         ext_use_ff   <= '0;
      end else begin
         file_size_ff <= file_size_in;
         ext_use_ff   <= ext_use_in;
      end
   end

   // ---------------------------------------------------------------
   // Command decode: loads go straight into the table, reads start
   // the divider and the sequencer together.
   // ---------------------------------------------------------------
   assign accept      = start && !busy;
   assign read_accept = accept && (req_data.op == OP_READ);

   // Loads to slots past the table depth are dropped.
   assign load_idx  = LIM_W'(req_data.extent_index);
   assign tbl_wr_en = accept && (req_data.op == OP_LOAD)
                   && (load_idx < LIM_W'(MAX_EXTENTS));
   assign tbl_wr_data.start  = req_data.extent_start;
   assign tbl_wr_data.blocks = req_data.extent_blocks;

   emrs_ext_table #(
      .MAX_EXTENTS (MAX_EXTENTS)
   ) u_table (
      .clock     (clock),
      .wr_en_i   (tbl_wr_en),
      .wr_addr_i (load_idx[IDX_W-1:0]),
      .wr_data_i (tbl_wr_data),
      .rd_addr_i (tbl_raddr),
      .rd_data_o (tbl_rd)
   );

   // Start position -> virtual block number and in-block offset.
   emrs_pos_div #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (read_accept),
      .dividend_i (req_data.read_position),
      .done_o     (div_done),
      .quot_o     (div_quot),
      .rem_o      (div_rem)
   );

   emrs_seq #(
      .MAX_EXTENTS (MAX_EXTENTS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .read_accept_i (read_accept),
      .req_pos_i     (req_data.read_position),
      .req_len_i     (req_data.read_length),
      .file_size_i   (file_size_ff),
      .ext_use_i     (ext_use_ff),
      .busy_o        (busy),
      .div_done_i    (div_done),
      .div_quot_i    (div_quot),
      .div_rem_i     (div_rem),
      .tbl_raddr_o   (tbl_raddr),
      .tbl_rd_i      (tbl_rd),
      .rsp_valid_o   (rsp_valid),
      .rsp_o         (rsp_data)
   );

endmodule

// ===== hw/rtl/emrs_checker.sv =====
// Port-level checker for the extent-mapped read segmenter, bound to the top level.
`timescale 1ns / 1ps

module emrs_checker
   import emrs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // Results only come out of a running read.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a running read");

   // An accepted read occupies the block.
   a_read_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.op == OP_READ)) |=> busy)
      else $error("read accepted but block not busy");

   // A load is absorbed without holding the block and yields nothing.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.op == OP_LOAD)) |=> (!busy && !rsp_valid))
      else $error("load produced a result or held the block");

   // Status results terminate the read and carry no bytes.
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_SEG))
         |-> (rsp_data.last && (rsp_data.byte_count == '0)))
      else $error("status result not final or carries bytes");

   // After the final result the block is free again.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> !busy)
      else $error("block still busy after final result");

endmodule

bind extent_mapped_read_segmenter emrs_checker u_emrs_checker (.*);
